@@ rtl/dnlc_pkg.sv @@
package dnlc_pkg;

  // Default sizes
  localparam int ENTRIES_DEF    = 32;
  localparam int NAME_BYTES_DEF = 14;
  localparam int NAME_MAX_BYTES = 14;
  localparam int NAME_MAX_W     = NAME_MAX_BYTES * 8;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_INVAL  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Input item
  typedef struct packed {
    mode_t        mode;
    logic [15:0]  device;
    logic [31:0]  parent_inode;
    logic [63:0]  name_low;
    logic [47:0]  name_high;
    logic [31:0]  inode_number;
  } in_t;

  // Result item
  typedef struct packed {
    logic         found;
    logic [31:0]  found_inode;
    logic [31:0]  hit_total;
    logic [31:0]  miss_total;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch a new item
    logic compare;  // compare key against all entries
    logic update;   // write back entries, counters and result
  } cmd_t;

  // Keep the first nbytes bytes, zero every byte after the first zero byte
  function automatic logic [NAME_MAX_W-1:0] normalize_name(
    input logic [NAME_MAX_W-1:0] raw,
    input int                    nbytes
  );
    logic [NAME_MAX_W-1:0] res;
    logic                  ended;
    logic [7:0]            v;
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_MAX_BYTES; b++) begin
      v = raw[b*8 +: 8];
      if (b >= nbytes || ended) begin
        v = 8'h00;
      end
      if (v == 8'h00) begin
        ended = 1'b1;
      end
      res[b*8 +: 8] = v;
    end
    return res;
  endfunction

endpackage

@@ rtl/directory_name_lookup_cache.sv @@
// Directory name lookup cache, fully associative, round-robin replacement.
// Input channel: request is taken at a rising edge with start high and busy
//   low. request.mode selects lookup, add/update, invalidate by inode or parent, or clear.
// Result channel: result is valid for exactly one cycle while done is high;
//   the receiver cannot stall it, so it must take it in that cycle.
// Every item gives one result: found and found_inode for lookups (zero
//   otherwise) plus the running hit and miss totals after the item.
// Sequence: the accepting edge starts a compare cycle against all entries,
//   then a write-back cycle loads the result, and done is high once it is loaded.
// Overlap: busy is high only during the compare cycle; the write-back cycle
//   overlaps the load of the next item.
// Reset (rst, synchronous): all entries invalid, replace pointer and both
//   totals zero. Entry contents are not cleared; no pass is needed, so an
//   item can be accepted in the first cycle after reset.
// Names are compared over NAME_BYTES bytes, zeroed after the first NUL byte.
module directory_name_lookup_cache
  import dnlc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  cmd_t cmd;

  dnlc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dnlc_datapath #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

endmodule

@@ rtl/dnlc_ctrl.sv @@
module dnlc_ctrl
  import dnlc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_COMP = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  // Only the compare cycle blocks a new item; update overlaps the next load
  assign busy   = (state == ST_COMP);
  assign accept = start && !busy;

  assign cmd.load    = accept;
  assign cmd.compare = (state == ST_COMP);
  assign cmd.update  = (state == ST_UPD);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_COMP;
      ST_COMP: state_next = ST_UPD;
      ST_UPD:  state_next = accept ? ST_COMP : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPD);
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_comp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_COMP))
    else $error("accepted item did not enter compare");
  a_comp_to_upd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP) |=> (state == ST_UPD))
    else $error("compare not followed by update");
  a_upd_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |=> done)
    else $error("update did not strobe a result");
`endif

endmodule

@@ rtl/dnlc_datapath.sv @@
module dnlc_datapath
  import dnlc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  in_t  request,
  output out_t result
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int NAME_W = NAME_BYTES * 8;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  // Latched item
  mode_t              req_mode;
  logic [15:0]        req_dev;
  logic [31:0]        req_parent;
  logic [NAME_W-1:0]  req_name;
  logic [31:0]        req_inode;

  // Entry storage
  logic [ENTRIES-1:0] ent_valid;
  logic [15:0]        ent_dev    [ENTRIES];
  logic [31:0]        ent_parent [ENTRIES];
  logic [NAME_W-1:0]  ent_name   [ENTRIES];
  logic [31:0]        ent_inode  [ENTRIES];
  logic [IDX_W-1:0]   rp;

  // Compare results
  logic [ENTRIES-1:0] key_eq, inv_eq;
  logic [ENTRIES-1:0] match_vec, inv_vec;

  // Update side
  logic               any_match;
  logic [IDX_W-1:0]   match_idx;
  logic               lookup_hit, lookup_miss;
  logic [31:0]        hit_cnt, hit_cnt_next;
  logic [31:0]        miss_cnt, miss_cnt_next;
  logic [NAME_MAX_W-1:0] norm_name;

  assign norm_name = normalize_name({request.name_high, request.name_low}, NAME_BYTES);

  // Item latch, name normalized on the way in
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode   <= request.mode;
      req_dev    <= request.device;
      req_parent <= request.parent_inode;
      req_name   <= norm_name[NAME_W-1:0];
      req_inode  <= request.inode_number;
    end
  end

  // Parallel compare against every entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_eq[i] = ent_valid[i] && (ent_dev[i] == req_dev) &&
                  (ent_parent[i] == req_parent) && (ent_name[i] == req_name);
      inv_eq[i] = ent_valid[i] && (ent_dev[i] == req_dev) &&
                  ((ent_inode[i] == req_inode) || (ent_parent[i] == req_inode));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      match_vec <= key_eq;
      inv_vec   <= inv_eq;
    end
  end

  // Lowest-numbered match
  always_comb begin
    match_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IDX_W'(i);
    end
  end

  assign any_match   = |match_vec;
  assign lookup_hit  = cmd.update && (req_mode == MODE_LOOKUP) && any_match;
  assign lookup_miss = cmd.update && (req_mode == MODE_LOOKUP) && !any_match;

  assign hit_cnt_next  = lookup_hit  ? hit_cnt + 32'd1  : hit_cnt;
  assign miss_cnt_next = lookup_miss ? miss_cnt + 32'd1 : miss_cnt;

  // Valid bits, replace pointer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rp        <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
    end else begin
      hit_cnt  <= hit_cnt_next;
      miss_cnt <= miss_cnt_next;
      if (cmd.update) begin
        unique case (req_mode)
          MODE_ADD: begin
            if (!any_match) begin
              ent_valid[rp] <= 1'b1;
              rp            <= (rp == LAST) ? '0 : rp + 1'b1;
            end
          end
          MODE_INVAL:  ent_valid <= ent_valid & ~inv_vec;
          MODE_CLEAR: begin
            ent_valid <= '0;
            rp        <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Entry payload write
  always_ff @(posedge clk) begin
    if (cmd.update && (req_mode == MODE_ADD)) begin
      if (any_match) begin
        ent_inode[match_idx] <= req_inode;
      end else begin
        ent_dev[rp]    <= req_dev;
        ent_parent[rp] <= req_parent;
        ent_name[rp]   <= req_name;
        ent_inode[rp]  <= req_inode;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.found       <= lookup_hit;
      result.found_inode <= lookup_hit ? ent_inode[match_idx] : 32'd0;
      result.hit_total   <= hit_cnt_next;
      result.miss_total  <= miss_cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_rp_range: assert property (@(posedge clk) disable iff (rst)
    rp <= LAST)
    else $error("replace pointer out of range");
`endif

endmodule

@@ tb/tb_directory_name_lookup_cache.sv @@
`timescale 1ns / 100ps

module tb_directory_name_lookup_cache;
  import dnlc_pkg::*;

  localparam int SLOTS        = ENTRIES_DEF;
  localparam int KEY_BYTES    = NAME_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1030;
  localparam int POOL_SIZE    = 40;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  in_t  request;
  out_t result;

  directory_name_lookup_cache u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // Shadow copy of the cache contents and totals
  logic                  cache_valid  [SLOTS];
  logic [15:0]           cache_dev    [SLOTS];
  logic [31:0]           cache_parent [SLOTS];
  logic [NAME_MAX_W-1:0] cache_name   [SLOTS];
  logic [31:0]           cache_ino    [SLOTS];
  int unsigned           next_victim;
  logic [31:0]           hit_count;
  logic [31:0]           miss_count;

  out_t        expected_q[$];
  int          mismatch_count;
  int unsigned cycle_count;
  int          quiet_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bytes past the first NUL (or past the key width) do not take part in the key
  function automatic logic [NAME_MAX_W-1:0] canon_name(input logic [NAME_MAX_W-1:0] raw);
    logic [NAME_MAX_W-1:0] nm;
    logic                  terminated;
    nm         = '0;
    terminated = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[b*8 +: 8] == 8'h00) terminated = 1'b1;
      if (!terminated) nm[b*8 +: 8] = raw[b*8 +: 8];
    end
    return nm;
  endfunction

  // Apply one item to the shadow cache and return the result it should give
  function automatic out_t predict_cache(input in_t item);
    out_t                  res;
    logic [NAME_MAX_W-1:0] nm;
    int                    hit_slot;
    res      = '0;
    nm       = canon_name({item.name_high, item.name_low});
    hit_slot = -1;
    // lowest-numbered match wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cache_valid[i] && cache_dev[i] == item.device &&
          cache_parent[i] == item.parent_inode && cache_name[i] == nm)
        hit_slot = i;
    end
    case (item.mode)
      MODE_LOOKUP: begin
        if (hit_slot >= 0) begin
          res.found       = 1'b1;
          res.found_inode = cache_ino[hit_slot];
          hit_count       = hit_count + 32'd1;
        end else begin
          miss_count = miss_count + 32'd1;
        end
      end
      MODE_ADD: begin
        if (hit_slot >= 0) begin
          cache_ino[hit_slot] = item.inode_number;
        end else begin
          // round-robin victim, valid or not
          cache_valid[next_victim]  = 1'b1;
          cache_dev[next_victim]    = item.device;
          cache_parent[next_victim] = item.parent_inode;
          cache_name[next_victim]   = nm;
          cache_ino[next_victim]    = item.inode_number;
          next_victim = (next_victim == SLOTS - 1) ? 0 : next_victim + 1;
        end
      end
      MODE_INVAL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (cache_valid[i] && cache_dev[i] == item.device &&
              (cache_ino[i] == item.inode_number || cache_parent[i] == item.inode_number))
            cache_valid[i] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) cache_valid[i] = 1'b0;
        next_victim = 0;
      end
    endcase
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  // Sender idle length: mostly none or short, a few long, some quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [NAME_MAX_W-1:0] str_name(input string s);
    logic [NAME_MAX_W-1:0] nm;
    nm = '0;
    for (int b = 0; b < s.len() && b < NAME_MAX_BYTES; b++) nm[b*8 +: 8] = s[b];
    return nm;
  endfunction

  // Random bytes after the terminator; the key must not change
  function automatic logic [NAME_MAX_W-1:0] add_junk(input logic [NAME_MAX_W-1:0] nm);
    logic [NAME_MAX_W-1:0] res;
    logic                  past_end;
    res      = nm;
    past_end = 1'b0;
    for (int b = 0; b < NAME_MAX_BYTES; b++) begin
      if (past_end) res[b*8 +: 8] = 8'($urandom);
      else if (nm[b*8 +: 8] == 8'h00) past_end = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [NAME_MAX_W-1:0] random_name();
    logic [NAME_MAX_W-1:0] nm;
    int                    len;
    nm  = '0;
    len = $urandom_range(0, NAME_MAX_BYTES);
    for (int b = 0; b < len; b++) nm[b*8 +: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  // Called at a falling edge; returns at a falling edge after the item is taken
  task automatic send_item(input in_t item);
    int gap;
    request = item;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_cache(item));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue(input mode_t op, input logic [15:0] dev, input logic [31:0] par,
                       input logic [NAME_MAX_W-1:0] nm, input logic [31:0] ino);
    in_t item;
    item.mode         = op;
    item.device       = dev;
    item.parent_inode = par;
    item.name_low     = nm[63:0];
    item.name_high    = nm[NAME_MAX_W-1:64];
    item.inode_number = ino;
    send_item(item);
  endtask

  // Basic lookup, insert and update at field extremes
  task automatic test_lookup_add();
    issue(MODE_LOOKUP, 16'h0000, 32'h0, '0, 32'h0);
    issue(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, {NAME_MAX_W{1'b1}}, 32'hFFFF_FFFF);
    issue(MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, {NAME_MAX_W{1'b1}}, 32'h0);
    // last name byte differs
    issue(MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, {8'hFE, {(NAME_MAX_W-8){1'b1}}}, 32'h0);
    issue(MODE_ADD, 16'h0000, 32'h0, '0, 32'h0);
    issue(MODE_LOOKUP, 16'h0000, 32'h0, '0, 32'hFFFF_FFFF);
    issue(MODE_ADD, 16'd5, 32'd100, str_name("ab"), 32'd7);
    issue(MODE_ADD, 16'd5, 32'd100, str_name("ab"), 32'd9);
    issue(MODE_LOOKUP, 16'd5, 32'd100, str_name("ab"), 32'd0);
  endtask

  // Terminated names: padding after the NUL is ignored on store and compare
  task automatic test_name_termination();
    issue(MODE_ADD, 16'd5, 32'd100, str_name("longer_name_14"), 32'd33);
    issue(MODE_LOOKUP, 16'd5, 32'd100, add_junk(str_name("ab")), 32'd0);
    issue(MODE_LOOKUP, 16'd5, 32'd100, str_name("a"), 32'd0);
    issue(MODE_LOOKUP, 16'd6, 32'd100, str_name("ab"), 32'd0);
    issue(MODE_ADD, 16'd6, 32'd9, add_junk(str_name("x")), 32'd55);
    issue(MODE_LOOKUP, 16'd6, 32'd9, str_name("x"), 32'd0);
  endtask

  // Invalidate by inode or parent on one device only, then clear everything
  task automatic test_invalidate_clear();
    issue(MODE_ADD, 16'd5, 32'd9, str_name("c"), 32'd11);
    issue(MODE_INVAL, 16'd5, 32'hFFFF_FFFF, {NAME_MAX_W{1'b1}}, 32'd9);
    issue(MODE_LOOKUP, 16'd5, 32'd100, str_name("ab"), 32'd0);
    issue(MODE_LOOKUP, 16'd5, 32'd9, str_name("c"), 32'd0);
    issue(MODE_LOOKUP, 16'd6, 32'd9, str_name("x"), 32'd0);
    issue(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, {NAME_MAX_W{1'b1}}, 32'hFFFF_FFFF);
    issue(MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, {NAME_MAX_W{1'b1}}, 32'h0);
    issue(MODE_ADD, 16'd3, 32'd4, str_name("after"), 32'd77);
    issue(MODE_LOOKUP, 16'd3, 32'd4, str_name("after"), 32'd0);
  endtask

  // Mostly traffic on a working set of keys, plus noise and rare clears
  task automatic test_random_traffic(input int count);
    in_t         pool [POOL_SIZE];
    logic [15:0] devs [2];
    logic [31:0] shared_vals [4];
    in_t         item;
    int          k;
    int          r;
    for (int n = 0; n < count; n++) begin
      // new working set every so often; shared values make invalidates bite
      if (n % 200 == 0) begin
        devs[0] = 16'($urandom);
        devs[1] = 16'($urandom);
        for (int i = 0; i < 4; i++) shared_vals[i] = $urandom;
        for (int i = 0; i < POOL_SIZE; i++) begin
          pool[i].mode         = MODE_LOOKUP;
          pool[i].device       = devs[$urandom_range(0, 1)];
          pool[i].parent_inode = $urandom_range(0, 1) ? shared_vals[$urandom_range(0, 3)]
                                                      : $urandom;
          {pool[i].name_high, pool[i].name_low} = random_name();
          pool[i].inode_number = $urandom_range(0, 1) ? shared_vals[$urandom_range(0, 3)]
                                                      : $urandom;
        end
      end
      k    = $urandom_range(0, POOL_SIZE - 1);
      item = pool[k];
      r    = $urandom_range(0, 999);
      if (r < 380) begin
        item.mode = MODE_LOOKUP;
      end else if (r < 660) begin
        item.mode = MODE_ADD;
        if ($urandom_range(0, 3) == 0) item.inode_number = $urandom;
      end else if (r < 740) begin
        item.mode = $urandom_range(0, 1) ? MODE_LOOKUP : MODE_ADD;
        {item.name_high, item.name_low} = add_junk({item.name_high, item.name_low});
      end else if (r < 840) begin
        item.mode = MODE_INVAL;
        case ($urandom_range(0, 2))
          0:       item.inode_number = pool[k].inode_number;
          1:       item.inode_number = pool[k].parent_inode;
          default: item.inode_number = $urandom;
        endcase
        item.parent_inode = $urandom;
        item.name_low     = {$urandom, $urandom};
        item.name_high    = {16'($urandom), 32'($urandom)};
      end else if (r < 995) begin
        // noise: fully random fields, often no terminator at all
        item.mode         = mode_t'($urandom_range(0, 2));
        item.device       = 16'($urandom);
        item.parent_inode = $urandom;
        item.name_low     = {$urandom, $urandom};
        item.name_high    = {16'($urandom), 32'($urandom)};
        item.inode_number = $urandom;
      end else begin
        item.mode         = MODE_CLEAR;
        item.device       = 16'($urandom);
        item.parent_inode = $urandom;
        item.inode_number = $urandom;
      end
      send_item(item);
    end
  endtask

  task automatic note_mismatch(input string what, input out_t want, input out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected found=%0d inode=%h hits=%0d misses=%0d,",
               $realtime, what, want.found, want.found_inode, want.hit_total,
               want.miss_total,
               "  got found=%0d inode=%h hits=%0d misses=%0d",
               got.found, got.found_inode, got.hit_total, got.miss_total);
  endtask

  // Result checker: every strobe must match the oldest pending expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result", '0, result);
      end else begin
        want = expected_q.pop_front();
        if (result.found !== want.found || result.found_inode !== want.found_inode ||
            result.hit_total !== want.hit_total || result.miss_total !== want.miss_total)
          note_mismatch("result mismatch", want, result);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("directory_name_lookup_cache verification failed");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    quiet_left     = 0;
    next_victim    = 0;
    hit_count      = '0;
    miss_count     = '0;
    for (int i = 0; i < SLOTS; i++) cache_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_lookup_add();
    test_name_termination();
    test_invalidate_clear();
    test_random_traffic(RANDOM_ITEMS);

    // drain, then keep watching for stray results
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("directory_name_lookup_cache verification clean");
    end else begin
      $display("directory_name_lookup_cache verification failed");
    end
    $finish;
  end

endmodule
